// ===== rtl/cst_pkg.sv =====
// ---------------------------------------------------------------------------
// Counting semaphore table: shared definitions
// Field widths, command and status codes, table entry layout and the control
// and status groups passed between the allocation bitmap and the top level.
// ---------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned TableDepth      = 32;
  localparam int unsigned SemCountDefault = 32;
  localparam int unsigned IdxW            = 5;
  localparam int unsigned CountW          = 16;
  localparam int unsigned WaitW           = 8;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_GET    = 2'd1,
    CMD_PUT    = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_WOKEN     = 3'd2,
    ST_NONE_FREE = 3'd3,
    ST_BAD_ID    = 3'd4,
    ST_LIMIT     = 3'd5
  } status_e;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [CountW-1:0] tokens;
    logic [WaitW-1:0]  waiters;
  } entry_t;

  // Update of the used bitmap at the end of an item.
  typedef struct packed {
    logic            set;
    logic            clr;
    logic [IdxW-1:0] idx;
  } bitmap_op_t;

  // Lookup results from the used bitmap.
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] free_idx;
    logic            hit;
  } alloc_status_t;

endpackage

// ===== rtl/cst_alloc.sv =====
// ---------------------------------------------------------------------------
// Counting semaphore table: allocation bitmap
// Holds one used bit per entry, finds the lowest free entry and checks
// whether an addressed entry exists and is in use.
// ---------------------------------------------------------------------------
module cst_alloc #(
  parameter int unsigned LiveEntries = cst_pkg::SemCountDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cst_pkg::bitmap_op_t        op_i,
  input  logic [cst_pkg::IdxW-1:0]   look_idx_i,
  output cst_pkg::alloc_status_t     status_o
);
  import cst_pkg::*;

  localparam int unsigned AW = (LiveEntries > 1) ? $clog2(LiveEntries) : 1;

  logic [LiveEntries-1:0] used_q, used_d;
  logic                   found;
  logic [IdxW-1:0]        free_idx;
  logic                   in_range;

  always_comb begin
    used_d = used_q;
    if (op_i.set) begin
      used_d[op_i.idx[AW-1:0]] = 1'b1;
    end
    if (op_i.clr) begin
      used_d[op_i.idx[AW-1:0]] = 1'b0;
    end
  end

  // Scanning from the top down leaves the lowest free entry selected.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = LiveEntries - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        found    = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign in_range = ({1'b0, look_idx_i} < (IdxW + 1)'(LiveEntries));

  always_comb begin
    status_o.found    = found;
    status_o.free_idx = free_idx;
    status_o.hit      = in_range && used_q[look_idx_i[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

endmodule

// ===== rtl/cst_table_mem.sv =====
// ---------------------------------------------------------------------------
// Counting semaphore table: entry memory
// Simple dual-port synchronous memory holding token and waiter counts,
// one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module cst_table_mem #(
  parameter int unsigned Depth = cst_pkg::SemCountDefault,
  parameter int unsigned AW    = 5
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  cst_pkg::entry_t   wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output cst_pkg::entry_t   rd_data_o
);
  import cst_pkg::*;

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/counting_semaphore_table_unit.sv =====
// ---------------------------------------------------------------------------
// Counting semaphore table unit
// Table of counting semaphores with create, get, put and delete commands.
// ---------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start_i / busy_o   cmd_i, sem_index_i, initial_count_i
//  result    done_o (strobe)    status_o, result_index_o, count_now_o
//
// The accept cycle of an item reads the entry memory, the next cycle modifies
// and writes it back, as the read of the entry memory is registered. The
// result strobe follows in the cycle after that, in the same cycle that the
// next item may be accepted. Reset clears the used bitmap, so the table is
// ready right after reset. The receiver cannot stall results.
// ---------------------------------------------------------------------------
module counting_semaphore_table_unit #(
  parameter int unsigned SEM_COUNT = cst_pkg::SemCountDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  cmd_i,
  input  logic [cst_pkg::IdxW-1:0]    sem_index_i,
  input  logic [cst_pkg::CountW-1:0]  initial_count_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [cst_pkg::IdxW-1:0]    result_index_o,
  output logic [cst_pkg::CountW-1:0]  count_now_o
);
  import cst_pkg::*;

  localparam int unsigned LiveEntries =
    (SEM_COUNT < TableDepth) ? SEM_COUNT : TableDepth;
  localparam int unsigned AW = (LiveEntries > 1) ? $clog2(LiveEntries) : 1;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [WaitW-1:0]  WaitMax  = '1;

  logic              accept;
  logic              busy_q;
  logic              done_q;
  cmd_e              cmd_q;
  logic [IdxW-1:0]   idx_q;
  logic              ok_q;
  logic [CountW-1:0] init_q;

  logic [2:0]        status_d, status_q;
  logic [IdxW-1:0]   rindex_d, rindex_q;
  logic [CountW-1:0] count_d, count_q;

  bitmap_op_t        bm_op;
  alloc_status_t     alloc_st;
  logic              wr_en;
  entry_t            wr_data;
  entry_t            rd_data;

  assign accept = start_i && !busy_q;

  cst_alloc #(
    .LiveEntries (LiveEntries)
  ) u_alloc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (bm_op),
    .look_idx_i (sem_index_i),
    .status_o   (alloc_st)
  );

  cst_table_mem #(
    .Depth (LiveEntries),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (sem_index_i[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Modify step, active in the cycle after an item is accepted.
  always_comb begin
    status_d        = ST_OK;
    rindex_d        = idx_q;
    count_d         = '0;
    wr_en           = 1'b0;
    wr_data         = rd_data;
    bm_op.set       = 1'b0;
    bm_op.clr       = 1'b0;
    bm_op.idx       = idx_q;
    if (cmd_q == CMD_CREATE) begin
      if (ok_q) begin
        count_d         = init_q;
        wr_en           = busy_q;
        wr_data.tokens  = init_q;
        wr_data.waiters = '0;
        bm_op.set       = busy_q;
      end else begin
        status_d = ST_NONE_FREE;
        rindex_d = '0;
      end
    end else if (!ok_q) begin
      status_d = ST_BAD_ID;
    end else begin
      case (cmd_q)
        CMD_GET: begin
          if (rd_data.tokens != '0) begin
            wr_data.tokens = rd_data.tokens - 1'b1;
            count_d        = wr_data.tokens;
            wr_en          = busy_q;
          end else if (rd_data.waiters == WaitMax) begin
            status_d = ST_LIMIT;
          end else begin
            wr_data.waiters = rd_data.waiters + 1'b1;
            wr_en           = busy_q;
            status_d        = ST_BLOCKED;
          end
        end
        CMD_PUT: begin
          if (rd_data.tokens == '0 && rd_data.waiters != '0) begin
            wr_data.waiters = rd_data.waiters - 1'b1;
            wr_en           = busy_q;
            status_d        = ST_WOKEN;
          end else if (rd_data.tokens == CountMax) begin
            status_d = ST_LIMIT;
            count_d  = rd_data.tokens;
          end else begin
            wr_data.tokens = rd_data.tokens + 1'b1;
            count_d        = wr_data.tokens;
            wr_en          = busy_q;
          end
        end
        CMD_DELETE: begin
          if (rd_data.waiters != '0) begin
            status_d = ST_LIMIT;
            count_d  = rd_data.tokens;
          end else begin
            bm_op.clr = busy_q;
          end
        end
        default: begin
          status_d = ST_BAD_ID;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      init_q <= initial_count_i;
      if (cmd_e'(cmd_i) == CMD_CREATE) begin
        idx_q <= alloc_st.free_idx;
        ok_q  <= alloc_st.found;
      end else begin
        idx_q <= sem_index_i;
        ok_q  <= alloc_st.hit;
      end
    end
    if (busy_q) begin
      status_q <= status_d;
      rindex_q <= rindex_d;
      count_q  <= count_d;
    end
  end

  assign busy_o         = busy_q;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_index_o = rindex_q;
  assign count_now_o    = count_q;

endmodule
